FILE: src/uihb_pkg.sv
// uihb_pkg: types, constants and helpers for the UDP/IPv4 header builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package uihb_pkg;

    localparam int MAX_PAYLOAD = 1472;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int WORD_COUNT  = 6;
    localparam int WORD_IDX_W  = $clog2(WORD_COUNT);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_TOS         = 8'h00;
    localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [15:0] IP_UDP_HDR_LEN = 16'd28;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
    localparam logic [3:0]  FULL_WORD_BYTES = 4'd8;
    localparam logic [3:0]  TAIL_WORD_BYTES = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_MAC     = 3'd0,
        REG_SOURCE_MAC   = 3'd1,
        REG_SOURCE_IP    = 3'd2,
        REG_DEST_IP      = 3'd3,
        REG_SOURCE_PORT  = 3'd4,
        REG_DEST_PORT    = 3'd5,
        REG_TIME_TO_LIVE = 3'd6
    } cfg_reg_e;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_present;
        logic        last_byte;
        logic [15:0] packet_ident;
    } in_item_t;

    typedef struct packed {
        logic [63:0] header_word;
        logic [3:0]  bytes_valid;
        logic        header_last;
        logic        length_error;
    } out_item_t;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  time_to_live;
    } cfg_t;

    typedef struct packed {
        logic [15:0]      sum;
        logic [15:0]      pad;
        logic [CNT_W-1:0] count;
        logic [15:0]      ident;
        logic             ovf;
    } snap_t;

    typedef struct packed {
        logic [15:0] total_len;
        logic [15:0] udp_len;
        logic [15:0] ident;
        logic [15:0] ip_csum;
        logic [15:0] udp_csum;
        logic        ovf;
    } hdr_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

FILE: src/uihb_acc.sv
// uihb_acc: per-byte length count and ones-complement payload sum.
// Snapshots the datagram totals on the last byte. Uses uihb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uihb_acc
    import uihb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    input  wire logic     hdr_done,
    output snap_t         snap,
    output logic          snap_valid
);

    logic [15:0]      sum_reg, sum_next, sum_upd;
    logic [CNT_W-1:0] count_reg, count_next, count_upd;
    logic [7:0]       held_reg, held_next, held_upd;
    logic             odd_reg, odd_next, odd_upd;
    logic [15:0]      ident_reg, ident_next, ident_upd;
    logic             ovf_reg, ovf_next, ovf_upd;
    logic             busy_reg, busy_next;
    logic             snap_valid_reg, snap_valid_next;
    snap_t            snap_reg, snap_next;
    logic             accept;
    logic             take;

    assign in_stall = busy_reg & in_data.last_byte;
    assign accept   = in_valid & ~in_stall;
    assign take     = accept & in_data.last_byte;

    always_comb
    begin
        sum_upd   = sum_reg;
        count_upd = count_reg;
        held_upd  = held_reg;
        odd_upd   = odd_reg;
        ident_upd = ident_reg;
        ovf_upd   = ovf_reg;
        if (count_reg == '0)
        begin
            ident_upd = in_data.packet_ident;
        end
        if (in_data.byte_present)
        begin
            if (count_reg < CNT_W'(MAX_PAYLOAD))
            begin
                if (odd_reg)
                begin
                    sum_upd = oc_add(sum_reg, {held_reg, in_data.payload_byte});
                    odd_upd = 1'b0;
                end
                else
                begin
                    held_upd = in_data.payload_byte;
                    odd_upd  = 1'b1;
                end
                count_upd = count_reg + 1'b1;
            end
            else
            begin
                ovf_upd = 1'b1;
            end
        end
    end

    always_comb
    begin
        sum_next        = sum_reg;
        count_next      = count_reg;
        held_next       = held_reg;
        odd_next        = odd_reg;
        ident_next      = ident_reg;
        ovf_next        = ovf_reg;
        busy_next       = busy_reg;
        snap_next       = snap_reg;
        snap_valid_next = 1'b0;
        if (hdr_done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            if (in_data.last_byte)
            begin
                snap_next.sum   = sum_upd;
                snap_next.pad   = odd_upd ? {held_upd, 8'h00} : 16'h0000;
                snap_next.count = count_upd;
                snap_next.ident = ident_upd;
                snap_next.ovf   = ovf_upd;
                snap_valid_next = 1'b1;
                busy_next       = 1'b1;
                sum_next        = '0;
                count_next      = '0;
                held_next       = '0;
                odd_next        = 1'b0;
                ident_next      = '0;
                ovf_next        = 1'b0;
            end
            else
            begin
                sum_next   = sum_upd;
                count_next = count_upd;
                held_next  = held_upd;
                odd_next   = odd_upd;
                ident_next = ident_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            count_reg      <= '0;
            held_reg       <= '0;
            odd_reg        <= 1'b0;
            ident_reg      <= '0;
            ovf_reg        <= 1'b0;
            busy_reg       <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            held_reg       <= held_next;
            odd_reg        <= odd_next;
            ident_reg      <= ident_next;
            ovf_reg        <= ovf_next;
            busy_reg       <= busy_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;

endmodule

`default_nettype wire

FILE: src/uihb_csum.sv
// uihb_csum: four-stage pipeline for lengths, IPv4 header and UDP checksums.
// Uses uihb_pkg; inputs held stable while a header is in flight.
`timescale 1ns / 1ps
`default_nettype none

module uihb_csum
    import uihb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire snap_t snap,
    input  wire logic  snap_valid,
    input  wire cfg_t  cfg,
    output hdr_t       hdr,
    output logic       hdr_valid
);

    logic [15:0] total_len_reg, total_len_next;
    logic [15:0] udp_len_reg, udp_len_next;
    logic [17:0] addr_sum_reg, addr_sum_next;
    logic [19:0] ip_raw_reg, ip_raw_next;
    logic [19:0] udp_raw_reg, udp_raw_next;
    logic [16:0] ip_fold_reg, ip_fold_next;
    logic [16:0] udp_fold_reg, udp_fold_next;
    logic [15:0] ip_csum_reg, ip_csum_next;
    logic [15:0] udp_csum_reg, udp_csum_next;
    logic [3:0]  stage_valid_reg, stage_valid_next;

    always_comb
    begin
        total_len_next = IP_UDP_HDR_LEN + 16'(snap.count);
        udp_len_next   = UDP_HDR_LEN + 16'(snap.count);
        addr_sum_next  = 18'(cfg.source_ip[31:16]) + 18'(cfg.source_ip[15:0])
                       + 18'(cfg.dest_ip[31:16]) + 18'(cfg.dest_ip[15:0]);

        ip_raw_next = 20'({IP_VER_IHL, IP_TOS}) + 20'(IP_FLAGS_DF) + 20'(total_len_reg)
                    + 20'(snap.ident) + 20'({cfg.time_to_live, IP_PROTO_UDP})
                    + 20'(addr_sum_reg);
        udp_raw_next = 20'(snap.sum) + 20'(snap.pad) + 20'(addr_sum_reg)
                     + 20'(IP_PROTO_UDP) + 20'(udp_len_reg) + 20'(udp_len_reg)
                     + 20'(cfg.source_port) + 20'(cfg.dest_port);

        ip_fold_next  = 17'(ip_raw_reg[15:0]) + 17'(ip_raw_reg[19:16]);
        udp_fold_next = 17'(udp_raw_reg[15:0]) + 17'(udp_raw_reg[19:16]);

        ip_csum_next  = ~(ip_fold_reg[15:0] + {15'd0, ip_fold_reg[16]});
        udp_csum_next = ~(udp_fold_reg[15:0] + {15'd0, udp_fold_reg[16]});

        stage_valid_next = {stage_valid_reg[2:0], snap_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_len_reg <= total_len_next;
        udp_len_reg   <= udp_len_next;
        addr_sum_reg  <= addr_sum_next;
        ip_raw_reg    <= ip_raw_next;
        udp_raw_reg   <= udp_raw_next;
        ip_fold_reg   <= ip_fold_next;
        udp_fold_reg  <= udp_fold_next;
        ip_csum_reg   <= ip_csum_next;
        udp_csum_reg  <= udp_csum_next;
    end

    assign hdr.total_len = total_len_reg;
    assign hdr.udp_len   = udp_len_reg;
    assign hdr.ident     = snap.ident;
    assign hdr.ip_csum   = ip_csum_reg;
    assign hdr.udp_csum  = udp_csum_reg;
    assign hdr.ovf       = snap.ovf;
    assign hdr_valid     = stage_valid_reg[3];

endmodule

`default_nettype wire

FILE: src/uihb_emit.sv
// uihb_emit: sequences the six header words into the output register.
// Uses uihb_pkg; header fields come from uihb_csum and the config registers.
`timescale 1ns / 1ps
`default_nettype none

module uihb_emit
    import uihb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire hdr_t hdr,
    input  wire logic hdr_valid,
    input  wire cfg_t cfg,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_item_t out_data,
    output logic      hdr_done
);

    localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(WORD_COUNT - 1);

    logic [WORD_IDX_W-1:0] idx_reg, idx_next, sel;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg, out_data_next;
    logic                  accept;
    logic                  load;
    logic [63:0]           word;

    assign accept   = out_valid_reg & ~out_stall;
    assign hdr_done = accept & (idx_reg == WORD_LAST);
    assign load     = hdr_valid | (accept & (idx_reg != WORD_LAST));
    assign sel      = hdr_valid ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        case (sel)
            3'd0: word = {cfg.dest_mac, cfg.source_mac[47:32]};
            3'd1: word = {cfg.source_mac[31:0], ETHERTYPE_IPV4, IP_VER_IHL, IP_TOS};
            3'd2: word = {hdr.total_len, hdr.ident, IP_FLAGS_DF,
                          cfg.time_to_live, IP_PROTO_UDP};
            3'd3: word = {hdr.ip_csum, cfg.source_ip, cfg.dest_ip[31:16]};
            3'd4: word = {cfg.dest_ip[15:0], cfg.source_port, cfg.dest_port, hdr.udp_len};
            3'd5: word = {hdr.udp_csum, 48'h0};
            default: word = '0;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            idx_next                   = sel;
            out_valid_next             = 1'b1;
            out_data_next.header_word  = word;
            out_data_next.bytes_valid  = (sel == WORD_LAST) ? TAIL_WORD_BYTES
                                                            : FULL_WORD_BYTES;
            out_data_next.header_last  = (sel == WORD_LAST);
            out_data_next.length_error = hdr.ovf;
        end
        else if (accept)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: src/udp_ipv4_header_builder.sv
// udp_ipv4_header_builder: top level, config registers and block wiring.
// Depends on uihb_pkg, uihb_acc, uihb_csum and uihb_emit.
// Payload bytes are taken one per cycle while in_stall is low. After the last
// byte, uihb_csum builds the header; six words, one per cycle unless stalled.
// A last byte is stalled while the previous header is still in flight.
// Reset clears the datagram state; time_to_live resets to 56, other regs to 0.
`timescale 1ns / 1ps
`default_nettype none

module udp_ipv4_header_builder
    import uihb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    snap_t snap;
    logic  snap_valid;
    hdr_t  hdr;
    logic  hdr_valid;
    logic  hdr_done;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_DEST_MAC:     cfg_next.dest_mac     = cfg_data[47:0];
                REG_SOURCE_MAC:   cfg_next.source_mac   = cfg_data[47:0];
                REG_SOURCE_IP:    cfg_next.source_ip    = cfg_data[31:0];
                REG_DEST_IP:      cfg_next.dest_ip      = cfg_data[31:0];
                REG_SOURCE_PORT:  cfg_next.source_port  = cfg_data[15:0];
                REG_DEST_PORT:    cfg_next.dest_port    = cfg_data[15:0];
                REG_TIME_TO_LIVE: cfg_next.time_to_live = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_mac     <= '0;
            cfg_reg.source_mac   <= '0;
            cfg_reg.source_ip    <= '0;
            cfg_reg.dest_ip      <= '0;
            cfg_reg.source_port  <= '0;
            cfg_reg.dest_port    <= '0;
            cfg_reg.time_to_live <= 8'd56;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    uihb_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .hdr_done   (hdr_done),
        .snap       (snap),
        .snap_valid (snap_valid)
    );

    uihb_csum u_csum (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_valid (snap_valid),
        .cfg        (cfg_reg),
        .hdr        (hdr),
        .hdr_valid  (hdr_valid)
    );

    uihb_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr),
        .hdr_valid (hdr_valid),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .hdr_done  (hdr_done)
    );

endmodule

`default_nettype wire
